[hw/rtl/sfb_pkg.sv]
// shared types, constants and byte selection for the serial frame builder
package sfb_pkg;

   localparam logic [7:0] HDR_HI = 8'hAA;
   localparam logic [7:0] HDR_LO = 8'h55;
   localparam logic [7:0] TRL_HI = 8'h0D;
   localparam logic [7:0] TRL_LO = 8'h0A;

   localparam logic KIND_START   = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   // result sequences one input transaction can cause
   typedef enum logic [2:0] {
      BURST_ERROR,
      BURST_START_OPEN,
      BURST_START_CLOSE,
      BURST_PAY_MID,
      BURST_PAY_CLOSE
   } burst_type;

   localparam logic [2:0] POS_HDR_HI = 3'd0;
   localparam logic [2:0] POS_HDR_LO = 3'd1;
   localparam logic [2:0] POS_CMD    = 3'd2;
   localparam logic [2:0] POS_DATA   = 3'd3;
   localparam logic [2:0] POS_CHK    = 3'd4;
   localparam logic [2:0] POS_TRL_HI = 3'd5;
   localparam logic [2:0] POS_TRL_LO = 3'd6;

   typedef struct packed {
      burst_type  burst;
      logic [7:0] cmd;
      logic [7:0] data;
      logic [7:0] chk;
   } desc_type;

   function automatic logic [2:0] final_step(input burst_type burst);
      logic [2:0] s;
      unique case (burst)
         BURST_START_OPEN:  s = 3'd3;
         BURST_START_CLOSE: s = 3'd6;
         BURST_PAY_CLOSE:   s = 3'd3;
         default:           s = 3'd0;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] byte_at(input desc_type d, input logic [2:0] step);
      logic [2:0] pos;
      logic [7:0] b;
      pos = ((d.burst == BURST_PAY_MID) || (d.burst == BURST_PAY_CLOSE)) ?
            3'(step + POS_DATA) : step;
      unique case (pos)
         POS_HDR_HI: b = HDR_HI;
         POS_HDR_LO: b = HDR_LO;
         POS_CMD:    b = d.cmd;
         POS_DATA:   b = d.data;
         POS_CHK:    b = d.chk;
         POS_TRL_HI: b = TRL_HI;
         POS_TRL_LO: b = TRL_LO;
         default:    b = 8'h00;
      endcase
      if (d.burst == BURST_ERROR) begin
         b = 8'h00;
      end
      return b;
   endfunction

endpackage

[hw/rtl/sfb_framer.sv]
// frame state tracking and input register holding one decoded transaction
module sfb_framer
   import sfb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_command,
   input  logic [7:0] req_payload_length,
   input  logic [7:0] req_payload_byte,
   output logic       pend_valid,
   output desc_type   pend_desc,
   input  logic       take
);

   logic       frame_open_ff, frame_open_in;
   logic [7:0] remaining_ff, remaining_in;
   logic [7:0] sum_ff, sum_in;
   logic       pend_valid_ff, pend_valid_in;
   desc_type   pend_ff, pend_in;
   desc_type   dec;
   logic       accept;
   logic [7:0] start_sum;
   logic [7:0] pay_sum;
   logic [7:0] pay_left;

   assign req_ready = !pend_valid_ff || take;
   assign accept    = req_valid && req_ready;
   assign start_sum = req_command + req_payload_length;
   assign pay_sum   = sum_ff + req_payload_byte;
   assign pay_left  = remaining_ff - 8'd1;

   always_comb begin
      dec           = '0;
      dec.burst     = BURST_ERROR;
      frame_open_in = frame_open_ff;
      remaining_in  = remaining_ff;
      sum_in        = sum_ff;
      if (req_kind == KIND_START) begin
         if (!frame_open_ff) begin
            dec.cmd  = req_command;
            dec.data = req_payload_length;
            dec.chk  = start_sum;
            if (req_payload_length == 8'd0) begin
               dec.burst = BURST_START_CLOSE;
            end else begin
               dec.burst     = BURST_START_OPEN;
               frame_open_in = 1'b1;
               remaining_in  = req_payload_length;
               sum_in        = start_sum;
            end
         end
      end else if (frame_open_ff) begin
         dec.data = req_payload_byte;
         dec.chk  = pay_sum;
         if (pay_left == 8'd0) begin
            dec.burst     = BURST_PAY_CLOSE;
            frame_open_in = 1'b0;
            remaining_in  = 8'd0;
            sum_in        = 8'd0;
         end else begin
            dec.burst    = BURST_PAY_MID;
            remaining_in = pay_left;
            sum_in       = pay_sum;
         end
      end
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (accept) begin
         pend_valid_in = 1'b1;
         pend_in       = dec;
      end else if (take) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         remaining_ff  <= 8'd0;
         sum_ff        <= 8'd0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            frame_open_ff <= frame_open_in;
            remaining_ff  <= remaining_in;
            sum_ff        <= sum_in;
         end
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

   assign pend_valid = pend_valid_ff;
   assign pend_desc  = pend_ff;

endmodule

[hw/rtl/sfb_serializer.sv]
// result register walking the bytes of one decoded transaction
module sfb_serializer
   import sfb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       pend_valid,
   input  desc_type   pend_desc,
   output logic       take,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_frame_end,
   output logic       rsp_error,
   output logic       rsp_last
);

   logic       cur_valid_ff, cur_valid_in;
   desc_type   cur_ff, cur_in;
   logic [2:0] step_ff, step_in;
   logic       is_last;
   logic       done;

   assign is_last = (step_ff == final_step(cur_ff.burst));
   assign done    = cur_valid_ff && rsp_ready && is_last;
   assign take    = pend_valid && (!cur_valid_ff || done);

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      step_in      = step_ff;
      if (take) begin
         cur_valid_in = 1'b1;
         cur_in       = pend_desc;
         step_in      = 3'd0;
      end else if (done) begin
         cur_valid_in = 1'b0;
      end else if (cur_valid_ff && rsp_ready) begin
         step_in = step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         step_ff      <= 3'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assign rsp_valid     = cur_valid_ff;
   assign rsp_out_byte  = byte_at(cur_ff, step_ff);
   assign rsp_error     = (cur_ff.burst == BURST_ERROR);
   assign rsp_last      = is_last;
   assign rsp_frame_end = is_last &&
                          ((cur_ff.burst == BURST_START_CLOSE) ||
                           (cur_ff.burst == BURST_PAY_CLOSE));

endmodule

[hw/rtl/serial_frame_builder_sum_checksum.sv]
// first result: an accepted transaction is held in the framer's pending register, then
//   in the serializer's current register, which takes it when the output stage is idle
// throughput: one result byte per cycle while rsp_ready is high; a transaction yields
//   1, 4 or 7 bytes (payload byte or error, start or final byte, zero-length start)
// mid-frame payload bytes stream at one transaction per cycle while rsp_ready stays high
// reset: synchronous, clears frame state, running checksum and both stages
module serial_frame_builder_sum_checksum
   import sfb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_command,
   input  logic [7:0] req_payload_length,
   input  logic [7:0] req_payload_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_frame_end,
   output logic       rsp_error,
   output logic       rsp_last
);

   logic     pend_valid;
   desc_type pend_desc;
   logic     take;

   sfb_framer u_framer (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_command        (req_command),
      .req_payload_length (req_payload_length),
      .req_payload_byte   (req_payload_byte),
      .pend_valid         (pend_valid),
      .pend_desc          (pend_desc),
      .take               (take)
   );

   sfb_serializer u_serializer (
      .clock         (clock),
      .reset         (reset),
      .pend_valid    (pend_valid),
      .pend_desc     (pend_desc),
      .take          (take),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_frame_end (rsp_frame_end),
      .rsp_error     (rsp_error),
      .rsp_last      (rsp_last)
   );

endmodule
